// File: sv/pcfc_pkg.sv
// Shared types and codes for the flow-control credit bucket block.
// No dependencies; every other file of the block imports this package.
package pcfc_pkg;

    localparam int FUNC_W     = 2;
    localparam int VF_W       = 6;
    localparam int CLS_W      = 2;
    localparam int FIELD_W    = 16;
    localparam int WEIGHT_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [FUNC_W-1:0] FUNC_CHECK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CONSUME = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_INIT    = 2'd3;

    localparam logic [CLS_W-1:0] CLS_POSTED     = 2'd0;
    localparam logic [CLS_W-1:0] CLS_NONPOSTED  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_COMPLETION = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_POSTED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_NONPOSTED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_COMPLETION = 2'd2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd1;

    typedef struct packed {
        logic capture;
        logic exec;
    } pcfc_cmd_t;

endpackage

// File: sv/pcfc_ctrl.sv
// Controller of the credit bucket block: sequences capture and execution of one beat.
// Depends on pcfc_pkg for the command struct.
module pcfc_ctrl
    import pcfc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output pcfc_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic out_free;

    assign s_ready     = (state_reg == S_IDLE);
    assign out_free    = !m_valid_reg || m_ready;
    assign cmd.capture = s_valid && s_ready;
    assign cmd.exec    = (state_reg == S_EXEC) && out_free;
    assign m_valid     = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.capture) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (cmd.exec) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: sv/pcfc_datapath.sv
// Datapath of the credit bucket block: bucket memories, weights and the update arithmetic.
// Depends on pcfc_pkg for codes, widths and the command struct.
module pcfc_datapath
    import pcfc_pkg::*;
#(
    parameter int NUM_VF     = 64,
    parameter int TOKEN_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pcfc_cmd_t             cmd,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic [VF_W-1:0]       s_vf_index,
    input  logic [CLS_W-1:0]      s_traffic_class,
    input  logic [FIELD_W-1:0]    s_credit_amount,
    input  logic [FIELD_W-1:0]    s_init_capacity,
    input  logic [FIELD_W-1:0]    s_init_posted,
    input  logic [FIELD_W-1:0]    s_init_nonposted,
    input  logic [FIELD_W-1:0]    s_init_completion,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_granted,
    output logic [FIELD_W-1:0]    m_tokens_now
);

    localparam int DEPTH  = (NUM_VF < (1 << VF_W)) ? NUM_VF : (1 << VF_W);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TB     = TOKEN_BITS;
    localparam int SUM_W  = ((TB > FIELD_W) ? TB : FIELD_W) + 1;

    logic [TB-1:0] posted_mem     [DEPTH];
    logic [TB-1:0] nonposted_mem  [DEPTH];
    logic [TB-1:0] completion_mem [DEPTH];
    logic [TB-1:0] capacity_mem   [DEPTH];
    logic [DEPTH-1:0] vld_reg;

    logic [WEIGHT_W-1:0] w_posted_reg;
    logic [WEIGHT_W-1:0] w_nonposted_reg;
    logic [WEIGHT_W-1:0] w_completion_reg;

    logic [FUNC_W-1:0]  func_reg;
    logic [CLS_W-1:0]   cls_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               hit_reg;
    logic [FIELD_W-1:0] credit_reg;
    logic [TB-1:0]      icap_reg;
    logic [TB-1:0]      ip_reg;
    logic [TB-1:0]      inp_reg;
    logic [TB-1:0]      icp_reg;
    logic [TB-1:0]      rd_p_reg;
    logic [TB-1:0]      rd_np_reg;
    logic [TB-1:0]      rd_cp_reg;
    logic [TB-1:0]      rd_cap_reg;
    logic               rd_vld_reg;
    logic               granted_reg;
    logic [FIELD_W-1:0] tokens_reg;

    logic [ADDR_W-1:0] addr_w;
    logic              in_range_w;
    logic [31:0]       icap_w;
    logic [31:0]       ip_w;
    logic [31:0]       inp_w;
    logic [31:0]       icp_w;

    assign addr_w     = s_vf_index[ADDR_W-1:0];
    assign in_range_w = (13'(s_vf_index) < 13'(NUM_VF));
    assign icap_w     = 32'(s_init_capacity);
    assign ip_w       = 32'(s_init_posted);
    assign inp_w      = 32'(s_init_nonposted);
    assign icp_w      = 32'(s_init_completion);

    logic [TB-1:0] cur_p, cur_np, cur_cp, cur_cap;
    logic [TB-1:0] max1, max2, max3;
    logic [TB-1:0] base_p, base_np, base_cp, base_cap;
    logic [TB-1:0] sel;
    logic [WEIGHT_W-1:0] wsel;
    logic          sel_ok;
    logic [31:0]   sel32;
    logic [31:0]   w32;
    logic          pass;
    logic [TB-1:0] diff;
    logic [SUM_W-1:0] sum;
    logic [TB-1:0] upd;
    logic [TB-1:0] new_sel;
    logic [TB-1:0] new_p, new_np, new_cp;
    logic          grant;
    logic [TB-1:0] now;
    logic [31:0]   now32;

    always_comb begin
        cur_p   = rd_vld_reg ? rd_p_reg   : '0;
        cur_np  = rd_vld_reg ? rd_np_reg  : '0;
        cur_cp  = rd_vld_reg ? rd_cp_reg  : '0;
        cur_cap = rd_vld_reg ? rd_cap_reg : '0;

        max1 = (ip_reg  > icap_reg) ? ip_reg  : icap_reg;
        max2 = (inp_reg > max1)     ? inp_reg : max1;
        max3 = (icp_reg > max2)     ? icp_reg : max2;

        if (func_reg == FUNC_INIT) begin
            base_p   = ip_reg;
            base_np  = inp_reg;
            base_cp  = icp_reg;
            base_cap = max3;
        end else begin
            base_p   = cur_p;
            base_np  = cur_np;
            base_cp  = cur_cp;
            base_cap = cur_cap;
        end

        unique case (cls_reg)
            CLS_POSTED: begin
                sel    = base_p;
                wsel   = w_posted_reg;
                sel_ok = 1'b1;
            end
            CLS_NONPOSTED: begin
                sel    = base_np;
                wsel   = w_nonposted_reg;
                sel_ok = 1'b1;
            end
            CLS_COMPLETION: begin
                sel    = base_cp;
                wsel   = w_completion_reg;
                sel_ok = 1'b1;
            end
            default: begin
                sel    = '0;
                wsel   = w_completion_reg;
                sel_ok = 1'b0;
            end
        endcase

        sel32 = 32'(sel);
        w32   = 32'(wsel);
        pass  = (sel32 >= w32);
        diff  = sel - w32[TB-1:0];
        sum   = SUM_W'(sel) + SUM_W'(credit_reg);
        upd   = (sum > SUM_W'(base_cap)) ? base_cap : sum[TB-1:0];

        unique case (func_reg)
            FUNC_CHECK:   new_sel = sel;
            FUNC_CONSUME: new_sel = pass ? diff : sel;
            FUNC_UPDATE:  new_sel = upd;
            FUNC_INIT:    new_sel = sel;
            default:      new_sel = sel;
        endcase

        grant = sel_ok && pass
                && ((func_reg == FUNC_CHECK) || (func_reg == FUNC_CONSUME));

        new_p  = (sel_ok && (cls_reg == CLS_POSTED))     ? new_sel : base_p;
        new_np = (sel_ok && (cls_reg == CLS_NONPOSTED))  ? new_sel : base_np;
        new_cp = (sel_ok && (cls_reg == CLS_COMPLETION)) ? new_sel : base_cp;

        now   = (hit_reg && sel_ok) ? new_sel : '0;
        now32 = 32'(now);
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg   <= s_func;
            cls_reg    <= s_traffic_class;
            addr_reg   <= addr_w;
            hit_reg    <= in_range_w;
            credit_reg <= s_credit_amount;
            icap_reg   <= icap_w[TB-1:0];
            ip_reg     <= ip_w[TB-1:0];
            inp_reg    <= inp_w[TB-1:0];
            icp_reg    <= icp_w[TB-1:0];
            rd_p_reg   <= posted_mem[addr_w];
            rd_np_reg  <= nonposted_mem[addr_w];
            rd_cp_reg  <= completion_mem[addr_w];
            rd_cap_reg <= capacity_mem[addr_w];
            rd_vld_reg <= vld_reg[addr_w];
        end
        if (cmd.exec && hit_reg) begin
            posted_mem[addr_reg]     <= new_p;
            nonposted_mem[addr_reg]  <= new_np;
            completion_mem[addr_reg] <= new_cp;
            capacity_mem[addr_reg]   <= base_cap;
        end
        if (cmd.exec) begin
            granted_reg <= hit_reg && grant;
            tokens_reg  <= now32[FIELD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg          <= '0;
            w_posted_reg     <= WEIGHT_RESET;
            w_nonposted_reg  <= WEIGHT_RESET;
            w_completion_reg <= WEIGHT_RESET;
        end else begin
            if (cmd.exec && hit_reg) begin
                vld_reg[addr_reg] <= 1'b1;
            end
            if (cfg_write) begin
                unique case (cfg_index)
                    CFG_WEIGHT_POSTED:     w_posted_reg     <= cfg_data;
                    CFG_WEIGHT_NONPOSTED:  w_nonposted_reg  <= cfg_data;
                    CFG_WEIGHT_COMPLETION: w_completion_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign m_granted    = granted_reg;
    assign m_tokens_now = tokens_reg;

endmodule

// File: sv/pcie_fc_credit_buckets.sv
// Flow-control credit buckets: an accepted input beat is registered in the capture
// registers, and its result is then registered in the output register and presented.
// A new beat is taken only once the last one has written back, set by the read-modify-write
// of the bucket memory: a registered read on acceptance, then the arithmetic and write-back.
// A waiting result in the output register delays the write-back cycle until it is taken.
// Reset sets the weights to one and clears the bucket valid bits at once; no clearing pass.
// Depends on pcfc_pkg, pcfc_ctrl and pcfc_datapath.
module pcie_fc_credit_buckets
    import pcfc_pkg::*;
#(
    parameter int NUM_VF     = 64,
    parameter int TOKEN_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic [VF_W-1:0]       s_vf_index,
    input  logic [CLS_W-1:0]      s_traffic_class,
    input  logic [FIELD_W-1:0]    s_credit_amount,
    input  logic [FIELD_W-1:0]    s_init_capacity,
    input  logic [FIELD_W-1:0]    s_init_posted,
    input  logic [FIELD_W-1:0]    s_init_nonposted,
    input  logic [FIELD_W-1:0]    s_init_completion,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_granted,
    output logic [FIELD_W-1:0]    m_tokens_now,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pcfc_cmd_t cmd;

    assign cfg_ready = 1'b1;

    pcfc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    pcfc_datapath #(
        .NUM_VF     (NUM_VF),
        .TOKEN_BITS (TOKEN_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .s_func            (s_func),
        .s_vf_index        (s_vf_index),
        .s_traffic_class   (s_traffic_class),
        .s_credit_amount   (s_credit_amount),
        .s_init_capacity   (s_init_capacity),
        .s_init_posted     (s_init_posted),
        .s_init_nonposted  (s_init_nonposted),
        .s_init_completion (s_init_completion),
        .cfg_write         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_granted         (m_granted),
        .m_tokens_now      (m_tokens_now)
    );

endmodule

// File: sv/pcfc_checker.sv
// Port-level checks for the credit bucket block, bound to its top level.
// Depends on pcfc_pkg for port widths.
module pcfc_checker
    import pcfc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_granted,
    input logic [FIELD_W-1:0]    m_tokens_now
);

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted) && $stable(m_tokens_now))
        else $error("result beat changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second input beat accepted while one is in flight");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (!m_valid || m_ready) |-> ##2 m_valid)
        else $error("no result two cycles after an accepted beat");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("handshake state not cleared by reset");

endmodule

bind pcie_fc_credit_buckets pcfc_checker u_pcfc_checker (.*);
